// ===== hdl/wpm_pkg.sv =====
package wpm_pkg;

  // Default store capacity in bytes
  localparam int MAX_CHARS_DEF = 256;

  // Input item operation codes
  localparam logic [1:0] OP_CLEAR_PAT = 2'd0;
  localparam logic [1:0] OP_ADD_PAT   = 2'd1;
  localparam logic [1:0] OP_ADD_TEXT  = 2'd2;
  localparam logic [1:0] OP_EVAL      = 2'd3;

  // Configuration register indexes
  localparam logic [7:0] REG_SYNTAX_MODE = 8'd0;
  localparam logic [7:0] REG_CASE_SENS   = 8'd1;

  // Wildcard characters
  localparam logic [7:0] CH_PERCENT    = 8'h25;
  localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
  localparam logic [7:0] CH_STAR       = 8'h2A;
  localparam logic [7:0] CH_QUESTION   = 8'h3F;

  // Matcher sequencer states
  typedef enum logic [1:0] {
    ENG_IDLE,
    ENG_FETCH,
    ENG_STEP,
    ENG_DONE
  } eng_state_t;

  // Top to matcher control
  typedef struct packed {
    logic start;
    logic take;
  } eng_ctl_t;

  // Matcher to top status
  typedef struct packed {
    logic done;
    logic matched;
  } eng_sts_t;

  // Fold A-Z to a-z, all other bytes unchanged
  function automatic logic [7:0] fold_az(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage

// ===== hdl/wpm_ram.sv =====
module wpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = wpm_pkg::MAX_CHARS_DEF
) (
  input  logic                                    clk,
  input  logic                                    wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                        wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                        rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // One write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

// ===== hdl/wpm_engine.sv =====
module wpm_engine #(
  parameter int MAX_CHARS = wpm_pkg::MAX_CHARS_DEF,
  localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1,
  localparam int LW = $clog2(MAX_CHARS + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  wpm_pkg::eng_ctl_t ctl,
  input  logic              syntax_mode,
  input  logic              case_sensitive,
  input  logic [LW-1:0]     plen,
  input  logic [LW-1:0]     tlen,
  output logic [AW-1:0]     p_addr,
  output logic [AW-1:0]     t_addr,
  input  logic [7:0]        p_data,
  input  logic [7:0]        t_data,
  output wpm_pkg::eng_sts_t sts
);

  wpm_pkg::eng_state_t state_r, state_nxt;

  logic [LW-1:0] pi_r, pi_nxt;
  logic [LW-1:0] ti_r, ti_nxt;
  logic [LW-1:0] anchor_p_r, anchor_p_nxt;
  logic [LW-1:0] anchor_t_r, anchor_t_nxt;
  logic          anchored_r, anchored_nxt;
  logic          tail_r, tail_nxt;
  logic          matched_r, matched_nxt;

  logic [7:0] any_run;
  logic [7:0] any_one;
  logic       exact;
  logic       bytes_eq;
  logic       p_valid;
  logic       p_run;
  logic       p_hit;
  logic       t_left;
  logic       fin;

  // Shared compare unit: mode decode and one pattern/text byte compare
  always_comb begin
    any_run  = syntax_mode ? wpm_pkg::CH_STAR : wpm_pkg::CH_PERCENT;
    any_one  = syntax_mode ? wpm_pkg::CH_QUESTION : wpm_pkg::CH_UNDERSCORE;
    exact    = !syntax_mode && case_sensitive;
    bytes_eq = exact ? (t_data == p_data)
                     : (wpm_pkg::fold_az(t_data) == wpm_pkg::fold_az(p_data));
    p_valid  = pi_r < plen;
    t_left   = ti_r < tlen;
    p_run    = p_valid && (p_data == any_run);
    p_hit    = p_valid && ((p_data == any_one) || bytes_eq);
    // walk ends this step: tail ran out of wildcards, or mismatch with no anchor
    if (tail_r) begin
      fin = !p_run;
    end else begin
      fin = t_left && !p_run && !p_hit && !anchored_r;
    end
  end

  // Store addresses follow the walk pointers
  assign p_addr = pi_r[AW-1:0];
  assign t_addr = ti_r[AW-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wpm_pkg::ENG_IDLE: begin
        if (ctl.start) begin
          state_nxt = wpm_pkg::ENG_FETCH;
        end
      end
      wpm_pkg::ENG_FETCH: begin
        state_nxt = wpm_pkg::ENG_STEP;
      end
      wpm_pkg::ENG_STEP: begin
        state_nxt = fin ? wpm_pkg::ENG_DONE : wpm_pkg::ENG_FETCH;
      end
      wpm_pkg::ENG_DONE: begin
        if (ctl.take) begin
          state_nxt = wpm_pkg::ENG_IDLE;
        end
      end
      default: begin
        state_nxt = wpm_pkg::ENG_IDLE;
      end
    endcase
  end

  // Walk pointers and anchor
  always_comb begin
    pi_nxt       = pi_r;
    ti_nxt       = ti_r;
    anchor_p_nxt = anchor_p_r;
    anchor_t_nxt = anchor_t_r;
    anchored_nxt = anchored_r;
    tail_nxt     = tail_r;
    matched_nxt  = matched_r;
    case (state_r)
      wpm_pkg::ENG_IDLE: begin
        if (ctl.start) begin
          pi_nxt       = '0;
          ti_nxt       = '0;
          anchored_nxt = 1'b0;
          tail_nxt     = 1'b0;
          matched_nxt  = 1'b0;
        end
      end
      wpm_pkg::ENG_STEP: begin
        if (tail_r) begin
          // trailing any-run wildcards after the text is used up
          if (p_run) begin
            pi_nxt = pi_r + 1'b1;
          end else begin
            matched_nxt = (pi_r == plen);
          end
        end else if (!t_left) begin
          tail_nxt = 1'b1;
        end else if (p_run) begin
          anchored_nxt = 1'b1;
          anchor_p_nxt = pi_r;
          anchor_t_nxt = ti_r;
          pi_nxt       = pi_r + 1'b1;
        end else if (p_hit) begin
          pi_nxt = pi_r + 1'b1;
          ti_nxt = ti_r + 1'b1;
        end else if (anchored_r) begin
          // backtrack: wildcard swallows one more text byte
          pi_nxt       = anchor_p_r + 1'b1;
          anchor_t_nxt = anchor_t_r + 1'b1;
          ti_nxt       = anchor_t_r + 1'b1;
        end else begin
          matched_nxt = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= wpm_pkg::ENG_IDLE;
    end else begin
      state_r <= state_nxt;
    end
    pi_r       <= pi_nxt;
    ti_r       <= ti_nxt;
    anchor_p_r <= anchor_p_nxt;
    anchor_t_r <= anchor_t_nxt;
    anchored_r <= anchored_nxt;
    tail_r     <= tail_nxt;
    matched_r  <= matched_nxt;
  end

  assign sts.done    = (state_r == wpm_pkg::ENG_DONE);
  assign sts.matched = matched_r;

endmodule

// ===== hdl/wildcard_pattern_matcher.sv =====
// Wildcard pattern matcher.
// Input channel (in_valid/in_ready, in_operation, in_char_byte): clear pattern,
// append a pattern byte, append a text byte, or evaluate the stored text.
// Clear and append items produce no result.
// An evaluate item produces one result item (out_matched, out_overflow) on
// the out_valid/out_ready channel; out_overflow forces out_matched low.
// Evaluate walks both byte stores with one shared compare unit; each walk
// step is a store read, then a compare/advance, since each store has a
// single registered read port. in_ready is low for the whole walk and rises
// again in the same cycle as out_valid, when the result is handed over.
// After evaluate the text store is emptied; the pattern is kept until a
// clear item.
// A stalled receiver holds the result in the output register; load items
// are still accepted, and a further evaluate waits before handing over.
// Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) is always ready;
// index 0 is syntax mode (0 LIKE, 1 glob), index 1 case sensitivity (LIKE only).
// Synchronous active-low reset empties both stores and clears overflow
// flags and configuration; no clearing pass is needed.
module wildcard_pattern_matcher #(
  parameter int MAX_CHARS = wpm_pkg::MAX_CHARS_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_char_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       out_matched,
  output logic       out_overflow,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_index,
  input  logic       cfg_data
);

  localparam int AW = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
  localparam int LW = $clog2(MAX_CHARS + 1);

  logic          syntax_mode_r;
  logic          case_sens_r;
  logic [LW-1:0] plen_r, plen_nxt;
  logic [LW-1:0] tlen_r, tlen_nxt;
  logic          pov_r, pov_nxt;
  logic          tov_r, tov_nxt;
  logic          busy_r, busy_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_matched_r, out_matched_nxt;
  logic          out_overflow_r, out_overflow_nxt;

  logic          in_acc;
  logic          p_full;
  logic          t_full;
  logic          p_wr;
  logic          t_wr;
  logic [AW-1:0] p_rd_addr;
  logic [AW-1:0] t_rd_addr;
  logic [7:0]    p_rd_data;
  logic [7:0]    t_rd_data;

  wpm_pkg::eng_ctl_t eng_ctl;
  wpm_pkg::eng_sts_t eng_sts;

  assign in_acc    = in_valid && in_ready;
  assign in_ready  = !busy_r;
  assign cfg_ready = 1'b1;
  assign p_full    = (plen_r >= LW'(MAX_CHARS));
  assign t_full    = (tlen_r >= LW'(MAX_CHARS));
  assign p_wr      = in_acc && (in_operation == wpm_pkg::OP_ADD_PAT) && !p_full;
  assign t_wr      = in_acc && (in_operation == wpm_pkg::OP_ADD_TEXT) && !t_full;

  // Matcher handshake: start on evaluate, hand over when output slot frees
  assign eng_ctl.start = in_acc && (in_operation == wpm_pkg::OP_EVAL);
  assign eng_ctl.take  = eng_sts.done && (!out_valid_r || out_ready);

  // Store lengths, overflow flags, busy and output register
  always_comb begin
    plen_nxt         = plen_r;
    tlen_nxt         = tlen_r;
    pov_nxt          = pov_r;
    tov_nxt          = tov_r;
    busy_nxt         = busy_r;
    out_valid_nxt    = out_valid_r;
    out_matched_nxt  = out_matched_r;
    out_overflow_nxt = out_overflow_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_acc) begin
      case (in_operation)
        wpm_pkg::OP_CLEAR_PAT: begin
          plen_nxt = '0;
          pov_nxt  = 1'b0;
        end
        wpm_pkg::OP_ADD_PAT: begin
          if (p_full) begin
            pov_nxt = 1'b1;
          end else begin
            plen_nxt = plen_r + 1'b1;
          end
        end
        wpm_pkg::OP_ADD_TEXT: begin
          if (t_full) begin
            tov_nxt = 1'b1;
          end else begin
            tlen_nxt = tlen_r + 1'b1;
          end
        end
        wpm_pkg::OP_EVAL: begin
          busy_nxt = 1'b1;
        end
        default: begin
        end
      endcase
    end
    if (eng_ctl.take) begin
      out_valid_nxt    = 1'b1;
      out_overflow_nxt = pov_r || tov_r;
      out_matched_nxt  = eng_sts.matched && !(pov_r || tov_r);
      tlen_nxt         = '0;
      tov_nxt          = 1'b0;
      busy_nxt         = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      plen_r        <= '0;
      tlen_r        <= '0;
      pov_r         <= 1'b0;
      tov_r         <= 1'b0;
      busy_r        <= 1'b0;
      out_valid_r   <= 1'b0;
      syntax_mode_r <= 1'b0;
      case_sens_r   <= 1'b0;
    end else begin
      plen_r      <= plen_nxt;
      tlen_r      <= tlen_nxt;
      pov_r       <= pov_nxt;
      tov_r       <= tov_nxt;
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
      // configuration registers; unknown indexes ignored
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          wpm_pkg::REG_SYNTAX_MODE: syntax_mode_r <= cfg_data;
          wpm_pkg::REG_CASE_SENS:   case_sens_r   <= cfg_data;
          default: begin
          end
        endcase
      end
    end
    out_matched_r  <= out_matched_nxt;
    out_overflow_r <= out_overflow_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_matched  = out_matched_r;
  assign out_overflow = out_overflow_r;

  // Pattern store
  wpm_ram #(
    .WIDTH (8),
    .DEPTH (MAX_CHARS)
  ) u_pat_ram (
    .clk     (clk),
    .wr_en   (p_wr),
    .wr_addr (plen_r[AW-1:0]),
    .wr_data (in_char_byte),
    .rd_addr (p_rd_addr),
    .rd_data (p_rd_data)
  );

  // Text store
  wpm_ram #(
    .WIDTH (8),
    .DEPTH (MAX_CHARS)
  ) u_txt_ram (
    .clk     (clk),
    .wr_en   (t_wr),
    .wr_addr (tlen_r[AW-1:0]),
    .wr_data (in_char_byte),
    .rd_addr (t_rd_addr),
    .rd_data (t_rd_data)
  );

  // Matching walk
  wpm_engine #(
    .MAX_CHARS (MAX_CHARS)
  ) u_engine (
    .clk            (clk),
    .rst_n          (rst_n),
    .ctl            (eng_ctl),
    .syntax_mode    (syntax_mode_r),
    .case_sensitive (case_sens_r),
    .plen           (plen_r),
    .tlen           (tlen_r),
    .p_addr         (p_rd_addr),
    .t_addr         (t_rd_addr),
    .p_data         (p_rd_data),
    .t_data         (t_rd_data),
    .sts            (eng_sts)
  );

endmodule
